[src/boyer_moore_search_assert.svh]
`ifndef BOYER_MOORE_SEARCH_ASSERT_SVH
`define BOYER_MOORE_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset
`define BMS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset
`define BMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bms_pkg.sv]
package bms_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned ALPHA_W       = $clog2(ALPHABET_SIZE);
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned LEN_REG_W     = 6;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned IN_DATA_W     = 8;
  localparam int unsigned OUT_DATA_W    = 64;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_LO     = 3'd1,
    CFG_PATTERN_MID    = 3'd2,
    CFG_PATTERN_UPPER  = 3'd3,
    CFG_PATTERN_TOP    = 3'd4
  } cfg_idx_e;

  // Controls broadcast to every compare cell
  typedef struct packed {
    logic shift_win;  // shift the text window by one byte
    logic load_pat;   // shift the pattern in by one byte
    logic step;       // move the compare token one cell on
    logic clear;      // drop the compare token
  } cell_ctrl_t;

  // Status of the table builder
  typedef struct packed {
    logic              busy;
    logic              load_valid;
    logic [BYTE_W-1:0] load_byte;
  } tbl_status_t;

endpackage

[src/boyer_moore_search.sv]
// Streaming exact byte-pattern search (Boyer-Moore).
// Configuration: write pattern_length (index 0) and the four 64-bit pattern
// byte words (indexes 1 to 4) through cfg_we_i / cfg_addr_i / cfg_data_i.
// Each write rebuilds the shift tables; a write to a mapped register also
// restarts the text. The rebuild clears the bad-character table, then fills
// it from the pattern_length pattern bytes, then runs the good-suffix pass.
// The same rebuild runs after reset. s_axis_tready stays low throughout.
// Text requests enter on s_axis (byte in tdata, tlast on the final byte),
// one at a time. A byte that completes no alignment goes from S_IDLE to
// S_EMIT and back; one that does runs the compare token down the cell row,
// one cell per cycle, right to left through the pattern, in S_SCAN, then
// S_SHIFT on a mismatch, then S_EMIT. A result (tuser = match found, tlast =
// end of text) is loaded into the m_axis register in S_EMIT for a match or
// the last byte. A new byte is taken while that result waits; when the receiver
// stalls and a second result is ready, the block holds until the first is taken.
module boyer_moore_search import bms_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // text in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic                  s_axis_tlast,  // last_byte
  // results out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] match_position, [63:32] match_total
  output logic                  m_axis_tuser,  // match_found
  output logic                  m_axis_tlast   // text_done
);

  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e st_q, st_d;

  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] text_off_q, text_off_d;
  logic [CNT_W-1:0] align_q, align_d;
  logic [CNT_W-1:0] matches_q, matches_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             found_q, found_d;
  logic             last_q, last_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             out_found_q;
  logic             out_done_q;
  logic [CNT_W-1:0] out_pos_q;
  logic [CNT_W-1:0] out_total_q;

  tbl_status_t      tbl_status;
  logic [LEN_W-1:0] m;
  logic [LEN_W-1:0] m_dec;
  logic [IDX_W-1:0] m_last;
  logic             bc_hit;
  logic [IDX_W-1:0] bc_idx;
  logic [IDX_W-1:0] i_idx;
  logic [LEN_W-1:0] gs_i;
  logic [LEN_W-1:0] gs0;

  cell_ctrl_t        ctrl;
  logic              tok0;
  logic              acc;
  logic              align_hit;
  logic              any_mis;
  logic              cfg_map_hit;
  logic [BYTE_W-1:0] probe_or;

  logic [BYTE_W-1:0] win_w   [PATTERN_MAX];
  logic [BYTE_W-1:0] pat_w   [PATTERN_MAX];
  logic [BYTE_W-1:0] probe_w [PATTERN_MAX];
  logic              tok_w   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] mis_vec;

  logic signed [LEN_W:0] i_s;
  logic signed [LEN_W:0] bc_diff;
  logic signed [LEN_W:0] gs_s;
  logic [LEN_W-1:0]      shift;

  // Pattern, shift tables and their builder
  bms_tables #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_tables (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i),
    .len_o     (m),
    .status_o  (tbl_status),
    .bc_addr_i (probe_or),
    .bc_hit_o  (bc_hit),
    .bc_idx_o  (bc_idx),
    .gs_idx_i  (i_idx),
    .gs_o      (gs_i),
    .gs0_o     (gs0)
  );

  // Row of compare cells; cell k holds text byte k back and pattern byte m-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0] win_in;
    logic [BYTE_W-1:0] pat_in;
    logic              tok_in;

    if (k == 0) begin : g_head
      assign win_in = s_axis_tdata[BYTE_W-1:0];
      assign pat_in = tbl_status.load_byte;
      assign tok_in = tok0;
    end else begin : g_body
      assign win_in = win_w[k-1];
      assign pat_in = pat_w[k-1];
      assign tok_in = tok_w[k-1];
    end

    bms_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .win_i  (win_in),
      .pat_i  (pat_in),
      .tok_i  (tok_in),
      .win_o  (win_w[k]),
      .pat_o  (pat_w[k]),
      .tok_o  (tok_w[k]),
      .mis_o  (mis_vec[k]),
      .probe_o(probe_w[k])
    );
  end

  // Byte under the token feeds the bad-character lookup
  always_comb begin
    probe_or = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      probe_or = probe_or | probe_w[k];
    end
  end

  assign any_mis = |mis_vec;
  assign m_dec   = m - LEN_W'(1);
  assign m_last  = m_dec[IDX_W-1:0];
  assign acc     = s_axis_tvalid & s_axis_tready;

  // Only writes to mapped registers restart the text
  assign cfg_map_hit = cfg_we_i & (cfg_addr_i <= CFG_PATTERN_TOP);

  assign s_axis_tready = (st_q == S_IDLE) & ~tbl_status.busy & ~cfg_we_i;

  // Alignment fully covered by the text once this byte lands
  assign align_hit = ((align_q + CNT_W'(m_dec)) == text_off_q);

  // Mismatch shift: larger of bad-character and good-suffix rules
  assign i_idx   = m_last - cnt_q;
  assign i_s     = $signed({1'b0, LEN_W'(i_idx)});
  assign bc_diff = bc_hit ? (i_s - $signed({1'b0, LEN_W'(bc_idx)})) : (i_s + 1'sb1);
  assign gs_s    = $signed({1'b0, gs_i});
  assign shift   = (bc_diff > gs_s) ? bc_diff[LEN_W-1:0] : gs_i;

  // Search sequencer
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    text_off_d  = text_off_q;
    align_d     = align_q;
    matches_d   = matches_q;
    pos_d       = pos_q;
    found_d     = found_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_load    = 1'b0;
    ctrl        = '0;
    tok0        = 1'b0;

    ctrl.load_pat = tbl_status.load_valid;

    unique case (st_q)
      S_IDLE: begin
        if (acc) begin
          ctrl.shift_win = 1'b1;
          text_off_d     = text_off_q + CNT_W'(1);
          last_d         = s_axis_tlast;
          found_d        = 1'b0;
          cnt_d          = '0;
          if (align_hit) begin
            ctrl.step = 1'b1;
            tok0      = 1'b1;
            st_d      = S_SCAN;
          end else begin
            st_d = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (any_mis) begin
          ctrl.clear = 1'b1;
          st_d       = S_SHIFT;
        end else if (cnt_q == m_last) begin
          ctrl.clear = 1'b1;
          found_d    = 1'b1;
          pos_d      = align_q;
          matches_d  = matches_q + CNT_W'(1);
          align_d    = align_q + CNT_W'(gs0);
          st_d       = S_EMIT;
        end else begin
          ctrl.step = 1'b1;
          cnt_d     = cnt_q + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        align_d = align_q + CNT_W'(shift);
        st_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!(found_q || last_q)) begin
          st_d = S_IDLE;
        end else if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
          if (last_q) begin
            text_off_d = '0;
            align_d    = '0;
            matches_d  = '0;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    // A write to a mapped register starts a new text
    if (cfg_map_hit) begin
      text_off_d = '0;
      align_d    = '0;
      matches_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      text_off_q  <= '0;
      align_q     <= '0;
      matches_q   <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      text_off_q  <= text_off_d;
      align_q     <= align_d;
      matches_q   <= matches_d;
      found_q     <= found_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      out_found_q <= found_q;
      out_done_q  <= last_q;
      out_pos_q   <= found_q ? pos_q : '0;
      out_total_q <= last_q ? matches_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_total_q, out_pos_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_done_q;

endmodule

[src/bms_cell.sv]
module bms_cell import bms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] win_i,
  input  logic [BYTE_W-1:0] pat_i,
  input  logic              tok_i,
  output logic [BYTE_W-1:0] win_o,
  output logic [BYTE_W-1:0] pat_o,
  output logic              tok_o,
  output logic              mis_o,
  output logic [BYTE_W-1:0] probe_o
);

  logic [BYTE_W-1:0] win_q;
  logic [BYTE_W-1:0] pat_q;
  logic              tok_q;
  logic              eq;

  // Window and pattern bytes move one cell on when told
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_win) begin
      win_q <= win_i;
    end
    if (ctrl_i.load_pat) begin
      pat_q <= pat_i;
    end
  end

  // Compare token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      tok_q <= 1'b0;
    end else if (ctrl_i.step) begin
      tok_q <= tok_i;
    end
  end

  assign eq      = (win_q == pat_q);
  assign tok_o   = tok_q & eq;
  assign mis_o   = tok_q & ~eq;
  assign probe_o = tok_q ? win_q : '0;
  assign win_o   = win_q;
  assign pat_o   = pat_q;

endmodule

[src/bms_tables.sv]
module bms_tables import bms_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 32,
  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [LEN_W-1:0]      len_o,
  output tbl_status_t           status_o,
  input  logic [BYTE_W-1:0]     bc_addr_i,
  output logic                  bc_hit_o,
  output logic [IDX_W-1:0]      bc_idx_o,
  input  logic [IDX_W-1:0]      gs_idx_i,
  output logic [LEN_W-1:0]      gs_o,
  output logic [LEN_W-1:0]      gs0_o
);

  typedef enum logic [5:0] {
    B_CLEAR = 6'b000001,
    B_BAD   = 6'b000010,
    B_GS_A  = 6'b000100,
    B_GS_B  = 6'b001000,
    B_FILL  = 6'b010000,
    B_DONE  = 6'b100000
  } build_e;

  localparam int unsigned      BC_W  = IDX_W + 1;
  localparam int unsigned      PAD_W = LEN_W + 1 - IDX_W;
  localparam logic signed [LEN_W:0] P_ONE = 1;

  // Configuration registers
  logic [LEN_REG_W-1:0] len_q;
  logic [BYTE_W-1:0]    pat_q [PATTERN_MAX];

  // Builder state
  build_e                 st_q, st_d;
  logic [ALPHA_W-1:0]     sweep_q, sweep_d;
  logic [IDX_W-1:0]       i_q, i_d;
  logic [IDX_W-1:0]       s_q, s_d;
  logic signed [LEN_W:0]  p_q, p_d;
  logic [BYTE_W-1:0]      hold_q, hold_d;

  // Tables
  logic [BC_W-1:0]  bc_mem [ALPHABET_SIZE];
  logic [BC_W-1:0]  bc_rd_q;
  logic [LEN_W-1:0] gs_q [PATTERN_MAX];

  logic [LEN_W-1:0]      m;
  logic [LEN_W-1:0]      m_dec;
  logic [IDX_W-1:0]      m_last;
  logic signed [LEN_W:0] sp;
  logic signed [LEN_W:0] p_reset;
  logic [IDX_W-1:0]      sp_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [BYTE_W-1:0]     rd_byte;
  logic [IDX_W-1:0]      s_dec;
  logic                  s_more;
  logic                  bc_we;
  logic [ALPHA_W-1:0]    bc_waddr;
  logic [BC_W-1:0]       bc_wdata;
  logic                  gs_init;
  logic                  gs_we;

  // Length in use: zero counts as one, clamp at the cell count
  always_comb begin
    if (len_q == '0) begin
      m = LEN_W'(1);
    end else if (len_q > LEN_REG_W'(PATTERN_MAX)) begin
      m = LEN_W'(PATTERN_MAX);
    end else begin
      m = len_q[LEN_W-1:0];
    end
  end

  assign m_dec   = m - LEN_W'(1);
  assign m_last  = m_dec[IDX_W-1:0];
  assign sp      = $signed({{PAD_W{1'b0}}, s_q}) + p_q;
  assign sp_idx  = sp[IDX_W-1:0];
  assign p_reset = $signed({1'b0, m}) - $signed({{PAD_W{1'b0}}, s_q});
  assign s_dec   = s_q - IDX_W'(1);
  assign s_more  = (s_q > IDX_W'(1));

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_REG_W'(1);
      for (int k = 0; k < PATTERN_MAX; k++) begin
        pat_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_PATTERN_LENGTH) begin
        len_q <= cfg_data_i[LEN_REG_W-1:0];
      end
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (cfg_addr_i == CFG_ADDR_W'(int'(CFG_PATTERN_LO) + (k >> 3))) begin
          pat_q[k] <= cfg_data_i[BYTE_W*(k & 7) +: BYTE_W];
        end
      end
    end
  end

  // Single pattern read port shared by the builder steps
  always_comb begin
    unique case (st_q)
      B_BAD:   rd_idx = i_q;
      B_GS_A:  rd_idx = sp_idx;
      B_GS_B:  rd_idx = p_q[IDX_W-1:0];
      default: rd_idx = '0;
    endcase
  end

  assign rd_byte = pat_q[rd_idx];

  // Builder: clear bad-character table, fill it, then good-suffix shifts
  always_comb begin
    st_d     = st_q;
    sweep_d  = sweep_q;
    i_d      = i_q;
    s_d      = s_q;
    p_d      = p_q;
    hold_d   = hold_q;
    bc_we    = 1'b0;
    bc_waddr = sweep_q;
    bc_wdata = '0;
    gs_init  = 1'b0;
    gs_we    = 1'b0;
    status_o = '0;

    unique case (st_q)
      B_CLEAR: begin
        bc_we   = 1'b1;
        gs_init = 1'b1;
        sweep_d = sweep_q + ALPHA_W'(1);
        i_d     = '0;
        if (sweep_q == ALPHA_W'(ALPHABET_SIZE - 1)) begin
          st_d = B_BAD;
        end
      end
      B_BAD: begin
        bc_we               = 1'b1;
        bc_waddr            = rd_byte;
        bc_wdata            = {1'b1, i_q};
        status_o.load_valid = 1'b1;
        status_o.load_byte  = rd_byte;
        i_d                 = i_q + IDX_W'(1);
        if (i_q == m_last) begin
          s_d  = m_last;
          p_d  = '0;
          st_d = (m_last != '0) ? B_GS_A : B_DONE;
        end
      end
      B_GS_A: begin
        if (p_q < 0) begin
          st_d = B_FILL;
        end else begin
          hold_d = rd_byte;
          st_d   = B_GS_B;
        end
      end
      B_GS_B: begin
        if (rd_byte == hold_q) begin
          p_d  = p_q - P_ONE;
          st_d = B_GS_A;
        end else begin
          gs_we = 1'b1;
          p_d   = p_reset;
          s_d   = s_dec;
          st_d  = s_more ? B_GS_A : B_DONE;
        end
      end
      B_FILL: begin
        gs_we = 1'b1;
        if (sp == '0) begin
          p_d  = p_reset;
          s_d  = s_dec;
          st_d = s_more ? B_GS_A : B_DONE;
        end else begin
          p_d = p_q - P_ONE;
        end
      end
      B_DONE: begin
        st_d = B_DONE;
      end
      default: begin
        st_d = B_CLEAR;
      end
    endcase

    // Any register write rebuilds the tables
    if (cfg_we_i) begin
      st_d    = B_CLEAR;
      sweep_d = '0;
    end

    status_o.busy = (st_q != B_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_CLEAR;
      sweep_q <= '0;
      i_q     <= '0;
      s_q     <= '0;
      p_q     <= '0;
    end else begin
      st_q    <= st_d;
      sweep_q <= sweep_d;
      i_q     <= i_d;
      s_q     <= s_d;
      p_q     <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  // Bad-character table: last pattern index of each byte value
  always_ff @(posedge clk_i) begin
    if (bc_we) begin
      bc_mem[bc_waddr] <= bc_wdata;
    end
    bc_rd_q <= bc_mem[bc_addr_i];
  end

  assign bc_hit_o = bc_rd_q[BC_W-1];
  assign bc_idx_o = bc_rd_q[IDX_W-1:0];

  // Good-suffix shifts
  always_ff @(posedge clk_i) begin
    if (gs_init) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        gs_q[k] <= m;
      end
    end else if (gs_we) begin
      gs_q[sp_idx] <= LEN_W'(s_q);
    end
  end

  assign gs_o  = gs_q[gs_idx_i];
  assign gs0_o = gs_q[0];
  assign len_o = m;

endmodule

[src/bms_checker.sv]
`include "boyer_moore_search_assert.svh"

module bms_checker import bms_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A stalled result holds
  `BMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

  // Results only for a match or the end of the text
  `BMS_ASSERT_NOW(a_out_kind, m_axis_tvalid, m_axis_tuser || m_axis_tlast, "result with neither match nor end")

  // Position field is zero when there was no match
  `BMS_ASSERT_NOW(a_pos_clear, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:0] == 32'd0, "position set without a match")

  // One text byte in work at a time
  `BMS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "byte taken while one is in work")

  // A register write blocks text while the tables are rebuilt
  `BMS_ASSERT_NEXT(a_cfg_rebuild, cfg_we_i, !s_axis_tready, "text taken during table rebuild")

endmodule

bind boyer_moore_search bms_checker u_bms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
